// ----- hdl/tkh_pkg.sv -----
// Shared types and constants for the top-k min-heap.
package tkh_pkg;

  localparam int unsigned SCORE_W = 32;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned TOPK_W  = 7;

  localparam logic [TOPK_W-1:0] TOPK_RESET = 7'd64;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // One heap record.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;
  } entry_t;

  // Sibling pair stored in one row of a level cell.
  typedef struct packed {
    entry_t left;
    entry_t right;
  } pair_t;

  // Command broadcast from the sequencer to the row of level cells.
  typedef struct packed {
    logic   rd;
    logic   wr;
    logic   half;
    entry_t data;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_CHECK,
    ST_REM_START,
    ST_REM_WAIT,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

endpackage

// ----- hdl/tkh_if.sv -----
// Channel interfaces: item input, result output and configuration write.
interface tkh_cmd_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [tkh_pkg::SCORE_W-1:0] new_score;
  logic        [tkh_pkg::TAG_W-1:0]   new_tag;

  modport source (output valid, action, new_score, new_tag, input ready);
  modport sink   (input valid, action, new_score, new_tag, output ready);
endinterface

interface tkh_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [tkh_pkg::SCORE_W-1:0] min_score;
  logic        [tkh_pkg::TAG_W-1:0]   min_tag;
  logic        [tkh_pkg::TOPK_W-1:0]  held_count;
  logic                               not_empty;
  logic                               taken;

  modport source (output valid, min_score, min_tag, held_count, not_empty, taken,
                  input ready);
  modport sink   (input valid, min_score, min_tag, held_count, not_empty, taken,
                  output ready);
endinterface

interface tkh_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tkh_pkg::TOPK_W-1:0]        top_k;

  modport source (output valid, top_k, input ready);
  modport sink   (input valid, top_k, output ready);
endinterface

// ----- hdl/tkh_level_cell.sv -----
// One heap level: sibling-pair storage with registered read, on the read-return chain.
module tkh_level_cell #(
  parameter int unsigned LEVEL      = 1,
  parameter int unsigned LEVEL_BITS = 3,
  parameter int unsigned ROW_BITS   = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tkh_pkg::cell_cmd_t    cmd,
  input  logic [LEVEL_BITS-1:0] sel_level,
  input  logic [ROW_BITS-1:0]   row,
  input  tkh_pkg::pair_t        rd_in,
  output tkh_pkg::pair_t        rd_out
);

  localparam int unsigned AW    = (LEVEL > 1) ? LEVEL - 1 : 1;
  localparam int unsigned DEPTH = 1 << AW;

  tkh_pkg::entry_t mem_l [DEPTH];
  tkh_pkg::entry_t mem_r [DEPTH];
  tkh_pkg::pair_t  rd_q;
  logic            rd_hit;
  logic            hit;
  logic [AW-1:0]   addr;

  assign hit  = (sel_level == LEVEL_BITS'(LEVEL));
  assign addr = row[AW-1:0];

  always_ff @(posedge clk) begin
    if (hit && cmd.wr) begin
      if (cmd.half) begin
        mem_r[addr] <= cmd.data;
      end else begin
        mem_l[addr] <= cmd.data;
      end
    end
    if (hit && cmd.rd) begin
      rd_q.left  <= mem_l[addr];
      rd_q.right <= mem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else begin
      rd_hit <= hit && cmd.rd;
    end
  end

  // Pass the upstream read data along unless this level answered.
  assign rd_out = rd_hit ? rd_q : rd_in;

endmodule

// ----- hdl/top_k_min_heap.sv -----
// Top level of the top-k min-heap: sequencer, root register and the row of level cells.
// Sequence, accepting edge to result valid: a rejected insert or an empty delete goes
//   straight to finish; an insert climbs from its new leaf through read and compare states;
//   a delete or a full insert walks down the same way; an insert over top_k also removes
//   the root. One item at a time: the input reopens in the cycle after the result loads,
//   and the result waits to load while an earlier result has not been taken.
// Reset: count clears to zero, top_k returns to 64; storage contents are left as they are.
module top_k_min_heap #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  tkh_cmd_if.sink          cmd,
  tkh_res_if.source        res,
  tkh_cfg_if.sink          cfg
);

  // CW holds a count up to CAPACITY and equals the number of heap levels.
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  // Node numbers are 1-based; a child of the last node still fits in NW bits.
  localparam int unsigned NW  = CW + 1;
  localparam int unsigned LW  = $clog2(CW + 1);
  localparam int unsigned RW  = (CW > 2) ? CW - 2 : 1;
  localparam int unsigned XW  = (CW > tkh_pkg::TOPK_W) ? CW : tkh_pkg::TOPK_W;

  // Heap level of a node: position of its leading one.
  function automatic logic [LW-1:0] node_level(input logic [NW-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int b = 0; b < NW; b++) begin
      if (v[b]) begin
        r = LW'(b);
      end
    end
    return r;
  endfunction

  tkh_pkg::state_t state, state_next;

  logic [CW-1:0]               count, count_next;
  logic [tkh_pkg::TOPK_W-1:0]  top_k;
  tkh_pkg::entry_t             root, root_next;   // node 1 lives here, not in a cell
  tkh_pkg::entry_t             cur, cur_next;     // record being sifted
  logic [NW-1:0]               node, node_next;   // hole position, 1-based
  logic [LW-1:0]               lvl, lvl_next;
  logic                        taken, taken_next;

  // Result register.
  logic                        res_valid;
  logic                        load_res;
  logic signed [tkh_pkg::SCORE_W-1:0] out_score;
  logic [tkh_pkg::TAG_W-1:0]   out_tag;
  logic [tkh_pkg::TOPK_W-1:0]  out_count;
  logic                        out_nonempty;
  logic                        out_taken;

  // Cell bus and read-return chain.
  tkh_pkg::cell_cmd_t          cell_cmd;
  logic [LW-1:0]               cell_lvl;
  logic [RW-1:0]               cell_row;
  tkh_pkg::pair_t              chain [CW];
  tkh_pkg::pair_t              rd_pair;

  // Helpers.
  tkh_pkg::entry_t             item;
  tkh_pkg::entry_t             par_entry;
  tkh_pkg::entry_t             best;
  logic [NW-1:0]               count_node;
  logic [NW-1:0]               parent;
  logic [NW-1:0]               child_l;
  logic [NW-1:0]               child_r;
  logic [NW-1:0]               best_node;
  logic                        left_ok;
  logic                        right_ok;
  logic                        go_left;
  logic                        go_right;
  logic                        below_limit;
  logic                        over_limit;
  logic                        ins_ok;

  assign item.score = cmd.new_score;
  assign item.tag   = cmd.new_tag;

  assign count_node = NW'(count);
  assign parent     = node >> 1;
  assign child_l    = {node[NW-2:0], 1'b0};
  assign child_r    = {node[NW-2:0], 1'b1};
  assign left_ok    = (child_l <= count_node);
  assign right_ok   = (child_r <= count_node);

  assign rd_pair    = chain[CW-1];
  // Parent of the hole sits in the half given by its own low bit, i.e. node bit 1.
  assign par_entry  = node[1] ? rd_pair.right : rd_pair.left;

  // Pick the smaller child, keeping the carried record on ties.
  assign go_left   = ($signed(cur.score) > $signed(rd_pair.left.score));
  assign go_right  = right_ok &&
                     (go_left ? ($signed(rd_pair.left.score) > $signed(rd_pair.right.score))
                              : ($signed(cur.score) > $signed(rd_pair.right.score)));
  assign best      = go_right ? rd_pair.right : rd_pair.left;
  assign best_node = go_right ? child_r : child_l;

  assign below_limit = (XW'(count) < XW'(top_k)) && (count != CW'(CAPACITY));
  assign over_limit  = (XW'(count) > XW'(top_k));
  assign ins_ok      = below_limit ||
                       ((count != '0) && ($signed(root.score) < $signed(cmd.new_score)));

  assign cmd.ready = (state == tkh_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;

  // Row of level cells; level 0 is the root register.
  assign chain[0] = '0;

  for (genvar k = 1; k < CW; k++) begin : g_level
    tkh_level_cell #(
      .LEVEL      (k),
      .LEVEL_BITS (LW),
      .ROW_BITS   (RW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cell_cmd),
      .sel_level (cell_lvl),
      .row       (cell_row),
      .rd_in     (chain[k-1]),
      .rd_out    (chain[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkh_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    root  <= root_next;
    cur   <= cur_next;
    node  <= node_next;
    lvl   <= lvl_next;
    taken <= taken_next;
  end

  // Configuration: take a write whenever one is offered.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_k <= tkh_pkg::TOPK_RESET;
    end else if (cfg.valid && cfg.ready) begin
      top_k <= cfg.top_k;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    root_next  = root;
    cur_next   = cur;
    node_next  = node;
    lvl_next   = lvl;
    taken_next = taken;
    load_res   = 1'b0;
    cell_cmd   = '0;
    cell_lvl   = lvl;
    cell_row   = parent[RW-1:0];

    case (state)
      tkh_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.action == tkh_pkg::ACT_DELETE) begin
            taken_next = 1'b0;
            state_next = (count == '0) ? tkh_pkg::ST_FINISH : tkh_pkg::ST_REM_START;
          end else begin
            taken_next = ins_ok;
            if (!ins_ok) begin
              state_next = tkh_pkg::ST_FINISH;
            end else if (count == CW'(CAPACITY)) begin
              // Full: overwrite the root and sift down.
              cur_next   = item;
              node_next  = NW'(1);
              lvl_next   = '0;
              state_next = tkh_pkg::ST_DN_RD;
            end else if (count == '0) begin
              root_next  = item;
              count_next = CW'(1);
              state_next = tkh_pkg::ST_CHECK;
            end else begin
              // Open a hole at the end and climb.
              cur_next   = item;
              count_next = count + CW'(1);
              node_next  = count_node + NW'(1);
              lvl_next   = node_level(count_node + NW'(1));
              state_next = tkh_pkg::ST_UP_RD;
            end
          end
        end
      end

      tkh_pkg::ST_UP_RD: begin
        if (lvl == LW'(1)) begin
          // Parent is the root register: compare and settle without a read.
          cell_cmd.wr   = 1'b1;
          cell_cmd.half = node[0];
          if ($signed(root.score) > $signed(cur.score)) begin
            cell_cmd.data = root;
            root_next     = cur;
          end else begin
            cell_cmd.data = cur;
          end
          state_next = tkh_pkg::ST_CHECK;
        end else begin
          cell_cmd.rd = 1'b1;
          cell_lvl    = lvl - LW'(1);
          cell_row    = parent[RW:1];
          state_next  = tkh_pkg::ST_UP_CMP;
        end
      end

      tkh_pkg::ST_UP_CMP: begin
        cell_cmd.wr   = 1'b1;
        cell_cmd.half = node[0];
        if ($signed(par_entry.score) > $signed(cur.score)) begin
          // Move the parent down into the hole and climb.
          cell_cmd.data = par_entry;
          node_next     = parent;
          lvl_next      = lvl - LW'(1);
          state_next    = tkh_pkg::ST_UP_RD;
        end else begin
          cell_cmd.data = cur;
          state_next    = tkh_pkg::ST_CHECK;
        end
      end

      tkh_pkg::ST_CHECK: begin
        state_next = over_limit ? tkh_pkg::ST_REM_START : tkh_pkg::ST_FINISH;
      end

      tkh_pkg::ST_REM_START: begin
        count_next = count - CW'(1);
        if (count == CW'(1)) begin
          state_next = tkh_pkg::ST_FINISH;
        end else begin
          // Fetch the last record; it refills the root.
          cell_cmd.rd = 1'b1;
          cell_lvl    = node_level(count_node);
          cell_row    = count_node[RW:1];
          state_next  = tkh_pkg::ST_REM_WAIT;
        end
      end

      tkh_pkg::ST_REM_WAIT: begin
        // The old last node is count + 1, so its half bit is the inverse of count[0].
        cur_next   = count[0] ? rd_pair.left : rd_pair.right;
        node_next  = NW'(1);
        lvl_next   = '0;
        state_next = tkh_pkg::ST_DN_RD;
      end

      tkh_pkg::ST_DN_RD: begin
        if (!left_ok) begin
          // Leaf reached: drop the carried record into the hole.
          if (node == NW'(1)) begin
            root_next = cur;
          end else begin
            cell_cmd.wr   = 1'b1;
            cell_cmd.half = node[0];
            cell_cmd.data = cur;
          end
          state_next = tkh_pkg::ST_FINISH;
        end else begin
          cell_cmd.rd = 1'b1;
          cell_lvl    = lvl + LW'(1);
          cell_row    = node[RW-1:0];
          state_next  = tkh_pkg::ST_DN_CMP;
        end
      end

      tkh_pkg::ST_DN_CMP: begin
        if (node == NW'(1)) begin
          root_next = (go_left || go_right) ? best : cur;
        end else begin
          cell_cmd.wr   = 1'b1;
          cell_cmd.half = node[0];
          cell_cmd.data = (go_left || go_right) ? best : cur;
        end
        if (go_left || go_right) begin
          node_next  = best_node;
          lvl_next   = lvl + LW'(1);
          state_next = tkh_pkg::ST_DN_RD;
        end else begin
          state_next = tkh_pkg::ST_FINISH;
        end
      end

      tkh_pkg::ST_FINISH: begin
        // Hold here until the result register is free.
        if (!res_valid || res.ready) begin
          load_res   = 1'b1;
          state_next = tkh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tkh_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register: loaded on finish, cleared by the downstream transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      out_nonempty <= (count != '0);
      out_score    <= (count != '0) ? root.score : '0;
      out_tag      <= (count != '0) ? root.tag : '0;
      out_count    <= tkh_pkg::TOPK_W'(count);
      out_taken    <= taken;
    end
  end

  assign res.valid      = res_valid;
  assign res.min_score  = out_score;
  assign res.min_tag    = out_tag;
  assign res.held_count = out_count;
  assign res.not_empty  = out_nonempty;
  assign res.taken      = out_taken;

  // The count never grows past the storage.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("heap count exceeds capacity");

  // The cell bus carries one operation per cycle.
  a_one_cell_op: assert property (@(posedge clk) disable iff (rst)
    !(cell_cmd.rd && cell_cmd.wr))
    else $error("read and write on the cell bus in the same cycle");

  // An accepted item closes the input until its work is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("second item accepted while one is in flight");

  // A delete never reports a taken insert.
  a_delete_not_taken: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && (cmd.action == tkh_pkg::ACT_DELETE)) |=> !taken)
    else $error("delete flagged as taken");

endmodule
